// File: hdl/pbu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbu_pkg: shared types and constants of the packed bit unpacker
// Register indexes, field widths, buffer size and the configuration bundle
// that travels from the register block to the unpack core.
// ----------------------------------------------------------------------------
package pbu_pkg;

  // Bit store size and derived widths
  localparam int unsigned BufBits   = 64;
  localparam int unsigned HeldW     = $clog2(BufBits + 1);
  localparam int unsigned ElemW     = 32;
  localparam int unsigned WidthW    = 6;
  localparam int unsigned CountW    = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxPerBeat = 8;
  localparam int unsigned BeatCntW  = $clog2(MaxPerBeat + 1);

  // Byte queue between front and back
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_ELEMENT_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ELEMENT_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIG_ENDIAN    = 2'd2;

  // Reset values of the registers
  localparam logic [WidthW-1:0] WidthReset = 6'd8;
  localparam logic [CountW-1:0] CountReset = 32'd1;

  // Configuration as seen by the core; width already clamped to 1..32
  typedef struct packed {
    logic [WidthW-1:0] width;
    logic [CountW-1:0] count;
    logic              big_endian;
  } cfg_t;

  // Width 0 acts as 1, widths above 32 act as 32
  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] raw);
    logic [WidthW-1:0] w;
    if (raw == '0) begin
      w = WidthW'(1);
    end else if (raw > WidthW'(ElemW)) begin
      w = WidthW'(ElemW);
    end else begin
      w = raw;
    end
    return w;
  endfunction

endpackage

// File: hdl/pbu_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbu_cfg_regs: configuration registers
// Plain write port; holds width, count and byte order and hands the core the
// effective width.
// ----------------------------------------------------------------------------
module pbu_cfg_regs
  import pbu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [WidthW-1:0] width_q;
  logic [CountW-1:0] count_q;
  logic              big_endian_q;

  // Register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WidthReset;
      count_q      <= CountReset;
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ELEMENT_WIDTH: width_q      <= cfg_data_i[WidthW-1:0];
        CFG_ELEMENT_COUNT: count_q      <= cfg_data_i[CountW-1:0];
        CFG_BIG_ENDIAN:    big_endian_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.width      = eff_width(width_q);
  assign cfg_o.count      = count_q;
  assign cfg_o.big_endian = big_endian_q;

endmodule

// File: hdl/pbu_byte_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbu_byte_queue: input front and byte queue
// Accepts packed bytes and buffers them so the unpack core can stall on its
// own while several elements drain from one byte.
// ----------------------------------------------------------------------------
module pbu_byte_queue
  import pbu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] packed_byte_i,
  output logic             in_stall_o,
  output logic             q_valid_o,
  output logic [ByteW-1:0] q_byte_o,
  input  logic             q_pop_i
);

  logic [ByteW-1:0] mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  // Stall only from the registered fill level
  assign in_stall_o = (cnt_q == QCntW'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_byte_o   = mem_q[rd_ptr_q];

  // Pointer and level update
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= packed_byte_i;
    end
  end

endmodule

// File: hdl/pbu_unpack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbu_unpack_core: bit store and element extraction
// Emits one element per cycle, while the output is not stalled, from the bit store into the output register and
// takes the next byte from the queue in the cycle its last element leaves.
// ----------------------------------------------------------------------------
module pbu_unpack_core
  import pbu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_valid_i,
  input  logic [ByteW-1:0] q_byte_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ElemW-1:0] element_value_o,
  output logic             last_element_o
);

  logic [BufBits-1:0]  store_q, store_d;
  logic [HeldW-1:0]    held_q, held_d;
  logic [CountW-1:0]   done_q, done_d;
  logic [BeatCntW-1:0] beat_cnt_q, beat_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [ElemW-1:0]    value_q, value_d;
  logic                last_q, last_d;

  logic [HeldW-1:0]    w_ext;
  logic [ElemW-1:0]    emask;
  logic [ElemW-1:0]    elem;
  logic [BufBits-1:0]  store_shift;
  logic                active, out_ready, emit, is_last, post_active, absorb;
  logic [BufBits-1:0]  base_store;
  logic [HeldW-1:0]    base_held, post_held, clamp_held;
  logic [CountW-1:0]   base_done;
  logic [BeatCntW-1:0] base_cnt;
  logic [BufBits-1:0]  byte_ext;

  assign w_ext = HeldW'(cfg_i.width);

  // Element extraction from the current store
  always_comb begin
    emask = 32'((33'h1 << cfg_i.width) - 33'h1);
    if (cfg_i.big_endian) begin
      elem        = 32'(store_q >> (HeldW'(BufBits) - w_ext)) & emask;
      store_shift = store_q << cfg_i.width;
    end else begin
      elem        = store_q[ElemW-1:0] & emask;
      store_shift = store_q >> cfg_i.width;
    end
  end

  // Emit and absorb decisions; a beat count of MaxPerBeat marks a closed byte
  assign active      = (held_q >= w_ext) && (beat_cnt_q < BeatCntW'(MaxPerBeat));
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign emit        = active && out_ready;
  assign is_last     = ({1'b0, done_q} + 33'd1) >= {1'b0, cfg_i.count};
  assign post_held   = held_q - w_ext;
  assign post_active = !is_last && (post_held >= w_ext)
                       && ((beat_cnt_q + BeatCntW'(1)) < BeatCntW'(MaxPerBeat));
  assign absorb      = q_valid_i && (!active || (emit && !post_active));
  assign q_pop_o     = absorb;
  assign byte_ext    = BufBits'(q_byte_i);

  // Next state of the bit store
  always_comb begin
    base_store = store_q;
    base_held  = held_q;
    base_done  = done_q;
    base_cnt   = beat_cnt_q;
    if (emit) begin
      if (is_last) begin
        base_store = '0;
        base_held  = '0;
        base_done  = '0;
        base_cnt   = BeatCntW'(MaxPerBeat);
      end else begin
        base_store = store_shift;
        base_held  = post_held;
        base_done  = done_q + CountW'(1);
        // Close the byte once its elements are out; held bits wait for the next byte
        base_cnt   = post_active ? beat_cnt_q + BeatCntW'(1) : BeatCntW'(MaxPerBeat);
      end
    end

    clamp_held = (base_held > HeldW'(ElemW)) ? HeldW'(ElemW) : base_held;
    store_d    = base_store;
    held_d     = base_held;
    done_d     = base_done;
    beat_cnt_d = base_cnt;
    if (absorb) begin
      if (cfg_i.big_endian) begin
        store_d = base_store | (byte_ext << (HeldW'(BufBits) - clamp_held - HeldW'(ByteW)));
      end else begin
        store_d = base_store | (byte_ext << clamp_held);
      end
      held_d     = clamp_held + HeldW'(ByteW);
      beat_cnt_d = (held_d >= w_ext) ? '0 : BeatCntW'(MaxPerBeat);
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    value_d     = value_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      value_d     = elem;
      last_d      = is_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q     <= '0;
      held_q      <= '0;
      done_q      <= '0;
      beat_cnt_q  <= BeatCntW'(MaxPerBeat);
      out_valid_q <= 1'b0;
    end else begin
      store_q     <= store_d;
      held_q      <= held_d;
      done_q      <= done_d;
      beat_cnt_q  <= beat_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign element_value_o = value_q;
  assign last_element_o  = last_q;

endmodule

// File: hdl/packed_bit_unpacker.sv
`timescale 1ns / 1ps
// Path: an accepted byte passes the queue and the bit store to the output register.
// Throughput: one output element per cycle while out_stall_i is low, set by the
//   single extract unit of the core; bytes flow at one per cycle while each byte
//   yields at most one element. Narrow widths yield up to 8 elements per byte.
// Reset: asynchronous, active low; clears queue, bit store, counters, output valid.
// ----------------------------------------------------------------------------
// packed_bit_unpacker: top level
// Unpacks densely packed unsigned elements of 1 to 32 bits from a byte stream,
// LSB-first or MSB-first, and flags the last element of each job.
// ----------------------------------------------------------------------------
module packed_bit_unpacker
  import pbu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    packed_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ElemW-1:0]    element_value_o,
  output logic                last_element_o
);

  cfg_t             cfg;
  logic             q_valid;
  logic [ByteW-1:0] q_byte;
  logic             q_pop;

  pbu_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pbu_byte_queue u_byte_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .packed_byte_i (packed_byte_i),
    .in_stall_o    (in_stall_o),
    .q_valid_o     (q_valid),
    .q_byte_o      (q_byte),
    .q_pop_i       (q_pop)
  );

  pbu_unpack_core u_unpack_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_valid_i       (q_valid),
    .q_byte_i        (q_byte),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_value_o (element_value_o),
    .last_element_o  (last_element_o)
  );

endmodule

// File: hdl/pbu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbu_checker: port-level checks of the packed bit unpacker
// Watches the top-level ports and tracks the element width from config writes.
// ----------------------------------------------------------------------------
module pbu_checker
  import pbu_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic [ByteW-1:0]    packed_byte_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [ElemW-1:0]    element_value_o,
  input  logic                last_element_o
);

  logic [WidthW-1:0] width_q;

  // Shadow of the effective element width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
    end else if (cfg_we_i && (cfg_index_i == CFG_ELEMENT_WIDTH)) begin
      width_q <= eff_width(cfg_data_i[WidthW-1:0]);
    end
  end

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_value_o)
      && $stable(last_element_o))
    else $error("output beat changed under stall");

  // A stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(packed_byte_i))
    else $error("input beat changed under stall");

  // Elements are zero-extended from the configured width
  a_zero_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((element_value_o >> width_q) == '0))
    else $error("element has bits above the configured width");

  // Reset empties the output side
  a_rst_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // Reset leaves the input side unstalled
  a_rst_in: assert property (@(posedge clk_i)
    !rst_ni |=> !in_stall_o)
    else $error("input stalled during reset");

endmodule

bind packed_bit_unpacker pbu_checker u_pbu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_index_i     (cfg_index_i),
  .cfg_data_i      (cfg_data_i),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .packed_byte_i   (packed_byte_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .element_value_o (element_value_o),
  .last_element_o  (last_element_o)
);
